>>> hw/rtl/sqltl_pkg.sv
// Shared types, token kinds, character codes and keyword table for the SQL token lexer.
package sqltl_pkg;

	localparam int KW_COUNT    = 14;
	localparam int KW_CHARS    = 6;
	localparam int QUEUE_DEPTH = 4;

	typedef logic [7:0] kw_word_t [KW_CHARS];

	localparam logic [5:0] K_EOF   = 6'd0;
	localparam logic [5:0] K_NUM   = 6'd1;
	localparam logic [5:0] K_IDENT = 6'd2;
	localparam logic [5:0] K_STR   = 6'd3;
	localparam logic [5:0] K_KW0   = 6'd4;
	localparam logic [5:0] K_EQ    = 6'd18;
	localparam logic [5:0] K_COMMA = 6'd19;
	localparam logic [5:0] K_SEMI  = 6'd20;
	localparam logic [5:0] K_LPAR  = 6'd21;
	localparam logic [5:0] K_RPAR  = 6'd22;
	localparam logic [5:0] K_STAR  = 6'd23;
	localparam logic [5:0] K_PLUS  = 6'd24;
	localparam logic [5:0] K_MINUS = 6'd25;
	localparam logic [5:0] K_SLASH = 6'd26;
	localparam logic [5:0] K_LT    = 6'd27;
	localparam logic [5:0] K_LE    = 6'd28;
	localparam logic [5:0] K_GT    = 6'd29;
	localparam logic [5:0] K_GE    = 6'd30;
	localparam logic [5:0] K_NE    = 6'd31;
	localparam logic [5:0] K_BAD   = 6'd32;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;

	localparam kw_word_t KW_TEXT [KW_COUNT] = '{
		'{"S", "E", "L", "E", "C", "T"},
		'{"F", "R", "O", "M", 8'h00, 8'h00},
		'{"W", "H", "E", "R", "E", 8'h00},
		'{"I", "N", "S", "E", "R", "T"},
		'{"I", "N", "T", "O", 8'h00, 8'h00},
		'{"V", "A", "L", "U", "E", "S"},
		'{"C", "R", "E", "A", "T", "E"},
		'{"T", "A", "B", "L", "E", 8'h00},
		'{"D", "E", "L", "E", "T", "E"},
		'{"U", "P", "D", "A", "T", "E"},
		'{"S", "E", "T", 8'h00, 8'h00, 8'h00},
		'{"A", "N", "D", 8'h00, 8'h00, 8'h00},
		'{"O", "R", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"N", "O", "T", 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd4, 4'd5, 4'd6, 4'd4, 4'd6, 4'd6,
		4'd5, 4'd6, 4'd6, 4'd3, 4'd3, 4'd2, 4'd3
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start_offset;
		logic [15:0] end_offset;
		logic        last;
	} rec_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c inside {[8'd9:8'd13]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {["A":"Z"], ["a":"z"]};
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c inside {["a":"z"]}) ? c - 8'd32 : c;
	endfunction

	function automatic logic [5:0] kw_kind(input kw_word_t w, input logic [3:0] len);
		logic [5:0] k;
		logic       hit;
		k = K_IDENT;
		for (int j = 0; j < KW_COUNT; j++) begin
			hit = (len == KW_LEN[j]);
			for (int i = 0; i < KW_CHARS; i++) begin
				hit = hit && (w[i] == KW_TEXT[j][i]);
			end
			if (hit) begin
				k = K_KW0 + 6'(j);
			end
		end
		return k;
	endfunction

endpackage

>>> hw/rtl/sql_token_lexer.sv
// Streaming SQL tokenizer: per-byte scanner with a small record queue on the output.
// Records of an accepted request are registered into the record queue when the request is accepted.
// Throughput: one request per cycle while s_tready is high; a request that completes two tokens
// pushes two records, popped one per handshake, and s_tready drops while the four-entry queue has under two free slots.
// Reset (arst_n low): scanner idle, offsets and word state cleared, record queue emptied.
// An end-of-input request returns the scanner to its reset state, so the next text starts at 0.
module sql_token_lexer #(
	parameter int OFFSET_BITS   = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] text_byte
	input  logic [0:0]  s_tuser,  // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [5:0] token_kind, [21:6] start_offset, [37:22] end_offset
	output logic        m_tlast
);

	localparam int OB = OFFSET_BITS;
	localparam int KC = KEYWORD_CHARS;
	localparam int LW = $clog2(KC + 2);
	localparam int QD = sqltl_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(QD);
	localparam int CW = $clog2(QD + 1);

	typedef enum logic [2:0] {
		M_IDLE, M_NUM, M_WORD, M_STR, M_STR_ESC, M_LT, M_GT, M_BANG
	} mode_t;

	mode_t          mode_q, n_mode, fr_mode;
	logic [OB-1:0]  off_q, start_q, n_off, n_start, off_inc;
	logic [7:0]     wbuf_q [KC];
	logic [7:0]     n_wbuf [KC];
	logic [LW-1:0]  len_q, n_len;

	sqltl_pkg::rec_t queue_q [QD];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   count_q;

	logic       acc, pop, act;
	logic [7:0] c;
	logic       fr_v;
	logic [5:0] fr_kind, wkind;
	logic       pend_v, sec_v, take_fresh;
	logic [5:0] pend_kind, sec_kind;
	logic [OB-1:0] pend_s, pend_e, sec_s, sec_e;
	sqltl_pkg::rec_t rec0, rec1;
	logic [1:0] n_push;
	sqltl_pkg::kw_word_t wcmp;

	function automatic logic [15:0] lo16(input logic [OB-1:0] v);
		logic [31:0] wide;
		wide = 32'(v);
		return wide[15:0];
	endfunction

	assign acc      = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;
	assign s_tready = (count_q <= CW'(QD - 2));
	assign m_tvalid = (count_q != '0);
	assign act      = s_tuser[0];
	assign c        = s_tdata;
	assign off_inc  = (off_q == '1) ? off_q : off_q + 1'b1;

	assign m_tdata = {2'b00, queue_q[rd_q].end_offset, queue_q[rd_q].start_offset,
		queue_q[rd_q].kind};
	assign m_tlast = queue_q[rd_q].last;

	always_comb begin
		for (int i = 0; i < sqltl_pkg::KW_CHARS; i++) begin
			wcmp[i] = wbuf_q[i];
		end
		wkind = sqltl_pkg::kw_kind(wcmp, 4'(len_q));
	end

	always_comb begin
		fr_mode = M_IDLE;
		fr_v    = 1'b0;
		fr_kind = sqltl_pkg::K_BAD;
		if (sqltl_pkg::is_space(c)) begin
			fr_mode = M_IDLE;
		end else if (sqltl_pkg::is_digit(c)) begin
			fr_mode = M_NUM;
		end else if (sqltl_pkg::is_alpha(c) || c == sqltl_pkg::CH_UNDER) begin
			fr_mode = M_WORD;
		end else begin
			case (c)
				sqltl_pkg::CH_QUOTE: fr_mode = M_STR;
				sqltl_pkg::CH_LT:    fr_mode = M_LT;
				sqltl_pkg::CH_GT:    fr_mode = M_GT;
				sqltl_pkg::CH_BANG:  fr_mode = M_BANG;
				sqltl_pkg::CH_EQ:    begin fr_v = 1'b1; fr_kind = sqltl_pkg::K_EQ;    end
				sqltl_pkg::CH_COMMA: begin fr_v = 1'b1; fr_kind = sqltl_pkg::K_COMMA; end
				sqltl_pkg::CH_SEMI:  begin fr_v = 1'b1; fr_kind = sqltl_pkg::K_SEMI;  end
				sqltl_pkg::CH_LPAR:  begin fr_v = 1'b1; fr_kind = sqltl_pkg::K_LPAR;  end
				sqltl_pkg::CH_RPAR:  begin fr_v = 1'b1; fr_kind = sqltl_pkg::K_RPAR;  end
				sqltl_pkg::CH_STAR:  begin fr_v = 1'b1; fr_kind = sqltl_pkg::K_STAR;  end
				sqltl_pkg::CH_PLUS:  begin fr_v = 1'b1; fr_kind = sqltl_pkg::K_PLUS;  end
				sqltl_pkg::CH_MINUS: begin fr_v = 1'b1; fr_kind = sqltl_pkg::K_MINUS; end
				sqltl_pkg::CH_SLASH: begin fr_v = 1'b1; fr_kind = sqltl_pkg::K_SLASH; end
				default:             begin fr_v = 1'b1; fr_kind = sqltl_pkg::K_BAD;   end
			endcase
		end
	end

	always_comb begin
		n_mode     = mode_q;
		n_off      = off_q;
		n_start    = start_q;
		n_wbuf     = wbuf_q;
		n_len      = len_q;
		pend_v     = 1'b0;
		pend_kind  = sqltl_pkg::K_BAD;
		pend_s     = start_q;
		pend_e     = off_q;
		sec_v      = 1'b0;
		sec_kind   = sqltl_pkg::K_EOF;
		sec_s      = off_q;
		sec_e      = off_inc;
		take_fresh = 1'b0;
		if (act) begin
			case (mode_q)
				M_NUM:             begin pend_v = 1'b1; pend_kind = sqltl_pkg::K_NUM; end
				M_WORD:            begin pend_v = 1'b1; pend_kind = wkind;            end
				M_STR, M_STR_ESC:  begin pend_v = 1'b1; pend_kind = sqltl_pkg::K_STR; end
				M_LT:              begin pend_v = 1'b1; pend_kind = sqltl_pkg::K_LT;  end
				M_GT:              begin pend_v = 1'b1; pend_kind = sqltl_pkg::K_GT;  end
				M_BANG:            begin pend_v = 1'b1; pend_kind = sqltl_pkg::K_BAD; end
				default:           pend_v = 1'b0;
			endcase
			sec_v    = 1'b1;
			sec_kind = sqltl_pkg::K_EOF;
			sec_e    = off_q;
			n_mode   = M_IDLE;
			n_off    = '0;
			n_start  = '0;
			n_len    = '0;
			for (int i = 0; i < KC; i++) begin
				n_wbuf[i] = 8'h00;
			end
		end else begin
			n_off = off_inc;
			case (mode_q)
				M_NUM: begin
					if (!(sqltl_pkg::is_digit(c) || c == sqltl_pkg::CH_DOT)) begin
						pend_v     = 1'b1;
						pend_kind  = sqltl_pkg::K_NUM;
						take_fresh = 1'b1;
					end
				end
				M_WORD: begin
					if (sqltl_pkg::is_alpha(c) || sqltl_pkg::is_digit(c) ||
						c == sqltl_pkg::CH_UNDER) begin
						for (int i = 0; i < KC; i++) begin
							if (len_q == LW'(i)) begin
								n_wbuf[i] = sqltl_pkg::upcase(c);
							end
						end
						if (len_q <= LW'(KC)) begin
							n_len = len_q + 1'b1;
						end
					end else begin
						pend_v     = 1'b1;
						pend_kind  = wkind;
						take_fresh = 1'b1;
					end
				end
				M_STR: begin
					if (c == sqltl_pkg::CH_QUOTE) begin
						pend_v    = 1'b1;
						pend_kind = sqltl_pkg::K_STR;
						pend_e    = off_inc;
						n_mode    = M_IDLE;
					end else if (c == sqltl_pkg::CH_BSLASH) begin
						n_mode = M_STR_ESC;
					end
				end
				M_STR_ESC: n_mode = M_STR;
				M_LT, M_GT, M_BANG: begin
					pend_v = 1'b1;
					if (c == sqltl_pkg::CH_EQ) begin
						pend_kind = (mode_q == M_LT) ? sqltl_pkg::K_LE :
							(mode_q == M_GT) ? sqltl_pkg::K_GE : sqltl_pkg::K_NE;
						pend_e = off_inc;
						n_mode = M_IDLE;
					end else begin
						pend_kind = (mode_q == M_LT) ? sqltl_pkg::K_LT :
							(mode_q == M_GT) ? sqltl_pkg::K_GT : sqltl_pkg::K_BAD;
						take_fresh = 1'b1;
					end
				end
				default: take_fresh = 1'b1;
			endcase
			if (take_fresh) begin
				n_mode   = fr_mode;
				n_start  = off_q;
				sec_v    = fr_v;
				sec_kind = fr_kind;
				if (fr_mode == M_WORD) begin
					for (int i = 0; i < KC; i++) begin
						n_wbuf[i] = 8'h00;
					end
					n_wbuf[0] = sqltl_pkg::upcase(c);
					n_len     = LW'(1);
				end
			end
		end
	end

	always_comb begin
		rec1.kind         = sec_kind;
		rec1.start_offset = lo16(sec_s);
		rec1.end_offset   = lo16(sec_e);
		rec1.last         = 1'b1;
		if (pend_v) begin
			rec0.kind         = pend_kind;
			rec0.start_offset = lo16(pend_s);
			rec0.end_offset   = lo16(pend_e);
			rec0.last         = !sec_v;
		end else begin
			rec0 = rec1;
		end
		n_push = {1'b0, pend_v} + {1'b0, sec_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			off_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			for (int i = 0; i < KC; i++) begin
				wbuf_q[i] <= 8'h00;
			end
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (acc) begin
				mode_q  <= n_mode;
				off_q   <= n_off;
				start_q <= n_start;
				len_q   <= n_len;
				wbuf_q  <= n_wbuf;
				wr_q    <= wr_q + PW'(n_push);
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + (acc ? CW'(n_push) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (acc && n_push != 2'd0) begin
			queue_q[wr_q] <= rec0;
		end
		if (acc && n_push == 2'd2) begin
			queue_q[wr_q + 1'b1] <= rec1;
		end
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QD))
		else $error("record queue overflow");

	a_eof_reset: assert property (@(posedge clk) disable iff (!arst_n)
		acc && act |=> off_q == '0 && mode_q == M_IDLE && len_q == '0)
		else $error("scanner not cleared after end of input");

	a_escape: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !act && mode_q == M_STR_ESC |=> mode_q == M_STR)
		else $error("escaped byte did not return to string mode");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !m_tlast |-> count_q >= CW'(2))
		else $error("first record of a pair sent without its partner queued");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(KC + 1))
		else $error("word length beyond saturation");

endmodule
